// ===== src/itt_pkg.sv =====
// Package: commands, states and default sizes of the id translation table.
`default_nettype none
package itt_pkg;
   localparam int TABLE_DEPTH_DEF  = 64;
   localparam int COUNTER_WRAP_DEF = 999;
   localparam int ID_W   = 32;
   localparam int BASE_W = 23;
   localparam int CMD_W  = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_FWD   = 3'd0,
      CMD_REV   = 3'd1,
      CMD_UPD   = 3'd2,
      CMD_ERASE = 3'd3,
      CMD_ALLOC = 3'd4,
      CMD_CLEAR = 3'd5,
      CMD_RSTAL = 3'd6,
      CMD_NOP   = 3'd7
   } cmd_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;
endpackage
`default_nettype wire

// ===== src/itt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module itt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== src/id_translation_table.sv =====
// Top level: id translation table with id allocator.
//
// Channel  Ports                                   Handshake
// request  req_command, req_key, req_value         start & !busy
// response rsp_result_id, rsp_found, rsp_status    rsp_valid, one cycle
// config   csr_base_id                             csr_valid & csr_ready
//
// Clear, reset allocator, command 7, a refused allocate and lookups of 0 / -1
// answer in the cycle after acceptance. Scans read both entry memories one
// entry a cycle; busy covers the scan of a lookup, update or erase (forward
// lookups, updates and erases end early on a hit), and the response comes
// in the first cycle with busy low; allocate rescans for each candidate id
// tried, up to COUNTER_WRAP-1 candidates. Reset is synchronous and empties
// the table at once. Results cannot be stalled; busy holds off new requests.
`default_nettype none
module id_translation_table #(
   parameter int TABLE_DEPTH  = itt_pkg::TABLE_DEPTH_DEF,
   parameter int COUNTER_WRAP = itt_pkg::COUNTER_WRAP_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [itt_pkg::CMD_W-1:0]   req_command,
   input  wire logic signed [itt_pkg::ID_W-1:0] req_key,
   input  wire logic signed [itt_pkg::ID_W-1:0] req_value,
   output logic                             rsp_valid,
   output logic signed [itt_pkg::ID_W-1:0]  rsp_result_id,
   output logic                             rsp_found,
   output logic                             rsp_status,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [itt_pkg::BASE_W-1:0]  csr_base_id
);
   import itt_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int PW = $clog2(TABLE_DEPTH + 1);
   localparam int NW = $clog2(TABLE_DEPTH + 1);
   localparam int CW = $clog2(COUNTER_WRAP);
   localparam logic [PW-1:0] DEPTH_P  = PW'(TABLE_DEPTH);
   localparam logic [CW-1:0] CTR_LAST = CW'(COUNTER_WRAP - 1);
   localparam logic [CW-1:0] TRY_LAST = CW'(COUNTER_WRAP - 2);
   localparam logic [ID_W-1:0] ID_ONES = '1;

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic [ID_W-1:0] key_ff, key_in, target_ff, target_in, val_ff, val_in;
   logic neg_ff, neg_in;
   logic [PW-1:0] addr_ff, addr_in;
   logic pend_ff, pend_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic free_fnd_ff, free_fnd_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;
   logic best_fnd_ff, best_fnd_in;
   logic [ID_W-1:0] best_ff, best_in;
   logic [CW-1:0] tries_ff, tries_in, ctr_ff, ctr_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [NW-1:0] count_ff, count_in;
   logic [BASE_W-1:0] base_ff;
   logic rsp_valid_ff, rsp_valid_in, rsp_found_ff, rsp_found_in;
   logic rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0] rsp_id_ff, rsp_id_in;

   logic wr_virt, wr_real;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [ID_W-1:0] virt_rd, real_rd, real_wr;
   logic accept, hit, scan_done, alloc_full;
   logic [CW-1:0] ctr_next;
   logic [ID_W-1:0] cand, neg_key;

   itt_ram #(.WIDTH(ID_W), .DEPTH(TABLE_DEPTH)) u_virt (
      .clock(clock), .wr_en(wr_virt), .wr_addr(wr_addr), .wr_data(key_ff),
      .rd_addr(rd_addr), .rd_data(virt_rd));
   itt_ram #(.WIDTH(ID_W), .DEPTH(TABLE_DEPTH)) u_real (
      .clock(clock), .wr_en(wr_real), .wr_addr(wr_addr), .wr_data(real_wr),
      .rd_addr(rd_addr), .rd_data(real_rd));

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rd_addr   = addr_ff[AW-1:0];
   assign real_wr   = val_ff;
   assign scan_done = (addr_ff == DEPTH_P) && !pend_ff;
   assign hit = pend_ff && valid_ff[idx_ff] &&
                ((cmd_ff == CMD_REV) ? (real_rd == target_ff) : (virt_rd == target_ff));
   assign ctr_next   = (ctr_ff == CTR_LAST) ? CW'(1) : ctr_ff + CW'(1);
   assign cand       = {{(ID_W-BASE_W){1'b0}}, base_ff} + ID_W'(ctr_ff);
   assign neg_key    = ID_W'(0) - req_key;
   assign alloc_full = (32'(count_ff) >= 32'(TABLE_DEPTH)) ||
                       (32'(count_ff) >= 32'(COUNTER_WRAP));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd_type'(req_command))
                  CMD_FWD, CMD_REV: begin
                     if ((cmd_type'(req_command) == CMD_FWD) ?
                         (req_key != '0 && req_key != ID_ONES) :
                         (req_value != '0 && req_value != ID_ONES)) begin
                        state_in = ST_SCAN;
                     end
                  end
                  CMD_UPD, CMD_ERASE: state_in = ST_SCAN;
                  CMD_ALLOC: if (!alloc_full) state_in = ST_SCAN;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            case (cmd_ff)
               CMD_REV: if (scan_done) state_in = ST_IDLE;
               CMD_ALLOC: begin
                  if (scan_done || (hit && tries_ff == TRY_LAST)) state_in = ST_IDLE;
               end
               default: if (hit || scan_done) state_in = ST_IDLE;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath, table edits and response
   always_comb begin
      cmd_in = cmd_ff; key_in = key_ff; target_in = target_ff; val_in = val_ff;
      neg_in = neg_ff; addr_in = addr_ff; pend_in = 1'b0; idx_in = idx_ff;
      free_fnd_in = free_fnd_ff; free_idx_in = free_idx_ff;
      best_fnd_in = best_fnd_ff; best_in = best_ff;
      tries_in = tries_ff; ctr_in = ctr_ff; valid_in = valid_ff; count_in = count_ff;
      rsp_valid_in = 1'b0; rsp_found_in = 1'b0; rsp_status_in = 1'b0; rsp_id_in = '0;
      wr_virt = 1'b0; wr_real = 1'b0; wr_addr = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in = cmd_type'(req_command);
               key_in = req_key; val_in = req_value;
               neg_in = req_key[ID_W-1];
               target_in = req_key[ID_W-1] ? neg_key : req_key;
               addr_in = '0; free_fnd_in = 1'b0; best_fnd_in = 1'b0;
               case (cmd_type'(req_command))
                  CMD_FWD: begin
                     if (req_key == '0 || req_key == ID_ONES) begin
                        rsp_valid_in = 1'b1; rsp_id_in = req_key;
                     end
                  end
                  CMD_REV: begin
                     target_in = req_value;
                     if (req_value == '0 || req_value == ID_ONES) begin
                        rsp_valid_in = 1'b1; rsp_id_in = req_value;
                     end
                  end
                  CMD_UPD, CMD_ERASE: target_in = req_key;
                  CMD_ALLOC: begin
                     if (alloc_full) begin
                        rsp_valid_in = 1'b1; rsp_status_in = 1'b1;
                     end else begin
                        target_in = cand; ctr_in = ctr_next; tries_in = '0;
                     end
                  end
                  CMD_CLEAR: begin
                     valid_in = '0; count_in = '0; rsp_valid_in = 1'b1;
                  end
                  CMD_RSTAL: begin
                     ctr_in = CW'(1); rsp_valid_in = 1'b1;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_SCAN: begin
            // issue next read, track compare slot
            if (addr_ff != DEPTH_P) begin
               pend_in = 1'b1; idx_in = addr_ff[AW-1:0]; addr_in = addr_ff + PW'(1);
            end
            if (pend_ff && !valid_ff[idx_ff] && !free_fnd_ff) begin
               free_fnd_in = 1'b1; free_idx_in = idx_ff;
            end
            case (cmd_ff)
               CMD_FWD: begin
                  if (hit || scan_done) begin
                     rsp_valid_in = 1'b1; rsp_found_in = hit;
                     rsp_id_in = !hit ? key_ff : (neg_ff ? ID_W'(0) - real_rd : real_rd);
                  end
               end
               CMD_REV: begin
                  if (hit && (!best_fnd_ff || $signed(virt_rd) < $signed(best_ff))) begin
                     best_fnd_in = 1'b1; best_in = virt_rd;
                  end
                  if (scan_done) begin
                     rsp_valid_in = 1'b1; rsp_found_in = best_fnd_ff;
                     rsp_id_in = best_fnd_ff ? best_ff : val_ff;
                  end
               end
               CMD_UPD: begin
                  if (hit) begin
                     wr_real = 1'b1; rsp_valid_in = 1'b1;
                  end else if (scan_done) begin
                     rsp_valid_in = 1'b1;
                     if (free_fnd_ff) begin
                        wr_addr = free_idx_ff; wr_virt = 1'b1; wr_real = 1'b1;
                        valid_in[free_idx_ff] = 1'b1; count_in = count_ff + NW'(1);
                     end else begin
                        rsp_status_in = 1'b1;
                     end
                  end
               end
               CMD_ERASE: begin
                  if (hit) begin
                     valid_in[idx_ff] = 1'b0; count_in = count_ff - NW'(1);
                  end
                  if (hit || scan_done) rsp_valid_in = 1'b1;
               end
               CMD_ALLOC: begin
                  if (scan_done) begin
                     rsp_valid_in = 1'b1; rsp_id_in = target_ff;
                  end else if (hit) begin
                     if (tries_ff == TRY_LAST) begin
                        rsp_valid_in = 1'b1; rsp_status_in = 1'b1;
                     end else begin
                        // retry with the next candidate id
                        target_in = cand; ctr_in = ctr_next; tries_in = tries_ff + CW'(1);
                        addr_in = '0; pend_in = 1'b0;
                     end
                  end
               end
               default: rsp_valid_in = 1'b1;
            endcase
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; valid_ff <= '0; count_ff <= '0; ctr_ff <= CW'(1);
         base_ff <= '0; rsp_valid_ff <= 1'b0; pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in; valid_ff <= valid_in; count_ff <= count_in;
         ctr_ff <= ctr_in; rsp_valid_ff <= rsp_valid_in; pend_ff <= pend_in;
         if (csr_valid && csr_ready) base_ff <= csr_base_id;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; key_ff <= key_in; target_ff <= target_in; val_ff <= val_in;
      neg_ff <= neg_in; addr_ff <= addr_in; idx_ff <= idx_in;
      free_fnd_ff <= free_fnd_in; free_idx_ff <= free_idx_in;
      best_fnd_ff <= best_fnd_in; best_ff <= best_in; tries_ff <= tries_in;
      rsp_found_ff <= rsp_found_in; rsp_status_ff <= rsp_status_in; rsp_id_ff <= rsp_id_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_result_id = rsp_id_ff;
endmodule
`default_nettype wire

// ===== src/itt_checker.sv =====
// Port checker for the id translation table, bound to the top level.
`default_nettype none
module itt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic [2:0]  req_command,
   input wire logic        rsp_valid,
   input wire logic [31:0] rsp_result_id,
   input wire logic        rsp_found,
   input wire logic        rsp_status
);
   import itt_pkg::*;

   // clear, reset allocator and nop commands answer next cycle
   a_quick: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_command == CMD_CLEAR || req_command == CMD_RSTAL ||
       req_command == CMD_NOP)) |=> rsp_valid) else $error("quick command no response");
   // a response never overlaps a busy cycle
   a_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while busy");
   // a hit is never a failure
   a_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> !rsp_status) else $error("found with error");
   // failures carry id zero
   a_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_result_id == '0)) else $error("error id nonzero");
endmodule

bind id_translation_table itt_checker u_itt_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_command(req_command), .rsp_valid(rsp_valid), .rsp_result_id(rsp_result_id),
   .rsp_found(rsp_found), .rsp_status(rsp_status));
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the id translation table: scoreboard class and top module.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import itt_pkg::*;

   localparam int DEPTH = TABLE_DEPTH_DEF;
   localparam int WRAP  = COUNTER_WRAP_DEF;

   typedef struct packed {
      logic signed [ID_W-1:0] result_id;
      logic                   found;
      logic                   status;
   } id_reply_type;

   // Shadow of the table: predicts the reply to every accepted request
   class id_table_scoreboard_type;
      bit                     used [DEPTH];
      logic [ID_W-1:0]        vid [DEPTH];
      logic [ID_W-1:0]        rid [DEPTH];
      int                     count;
      int                     counter;
      logic [BASE_W-1:0]      base;
      id_reply_type           pending [$];
      int                     errors;
      int                     replies;
      int                     hits;
      int                     fulls;

      function new();
         base = '0;
         errors = 0;
         replies = 0;
         hits = 0;
         fulls = 0;
         wipe();
         counter = 1;
      endfunction

      function void wipe();
         for (int i = 0; i < DEPTH; i++) used[i] = 0;
         count = 0;
      endfunction

      function int find_vid(logic [ID_W-1:0] v);
         for (int i = 0; i < DEPTH; i++)
            if (used[i] && vid[i] == v) return i;
         return -1;
      endfunction

      function int find_free();
         for (int i = 0; i < DEPTH; i++)
            if (!used[i]) return i;
         return -1;
      endfunction

      // Compute the reply for one request and queue it
      function void note_request(cmd_type cmd, logic [ID_W-1:0] key, logic [ID_W-1:0] val);
         id_reply_type    r;
         int              slot;
         bit              neg;
         logic [ID_W-1:0] look;
         logic [ID_W-1:0] best;
         logic [ID_W-1:0] cand;
         r = '0;
         best = '0;
         case (cmd)
            CMD_FWD: begin
               r.result_id = key;
               if (key != '0 && key != '1) begin
                  neg = key[ID_W-1];
                  look = neg ? -key : key;
                  slot = find_vid(look);
                  if (slot >= 0) begin
                     r.result_id = neg ? -rid[slot] : rid[slot];
                     r.found = 1;
                  end
               end
            end
            CMD_REV: begin
               r.result_id = val;
               if (val != '0 && val != '1) begin
                  // smallest signed virtual id wins
                  for (int i = 0; i < DEPTH; i++) begin
                     if (used[i] && rid[i] == val) begin
                        if (!r.found || (vid[i] ^ 32'h8000_0000) < best) begin
                           best = vid[i] ^ 32'h8000_0000;
                           r.result_id = vid[i];
                           r.found = 1;
                        end
                     end
                  end
               end
            end
            CMD_UPD: begin
               slot = find_vid(key);
               if (slot < 0) begin
                  slot = find_free();
                  if (slot >= 0) begin
                     used[slot] = 1;
                     vid[slot] = key;
                     count++;
                  end
               end
               if (slot < 0) r.status = 1;
               else rid[slot] = val;
            end
            CMD_ERASE: begin
               slot = find_vid(key);
               if (slot >= 0) begin
                  used[slot] = 0;
                  count--;
               end
            end
            CMD_ALLOC: begin
               r.status = 1;
               if (count < DEPTH && count < WRAP) begin
                  for (int i = 0; i < WRAP - 1; i++) begin
                     cand = ID_W'(base) + ID_W'(counter);
                     counter++;
                     if (counter >= WRAP) counter = 1;
                     if (find_vid(cand) < 0) begin
                        r.result_id = cand;
                        r.status = 0;
                        break;
                     end
                  end
               end
            end
            CMD_CLEAR: wipe();
            CMD_RSTAL: counter = 1;
            default: ;
         endcase
         if (r.found) hits++;
         if (r.status) fulls++;
         pending = {pending, r};
      endfunction

      // Compare one reply with the oldest prediction
      function void check_response(id_reply_type act);
         id_reply_type exp_r;
         replies++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("reply with nothing pending: id %0d found %0b status %0b",
                        act.result_id, act.found, act.status);
            return;
         end
         exp_r = pending.pop_front();
         if (exp_r.result_id !== act.result_id || exp_r.found !== act.found ||
             exp_r.status !== act.status) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp id %0d found %0b status %0b, got id %0d found %0b status %0b",
                        exp_r.result_id, exp_r.found, exp_r.status,
                        act.result_id, act.found, act.status);
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [CMD_W-1:0]       req_command;
   logic signed [ID_W-1:0] req_key;
   logic signed [ID_W-1:0] req_value;
   logic                   rsp_valid;
   logic signed [ID_W-1:0] rsp_result_id;
   logic                   rsp_found;
   logic                   rsp_status;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [BASE_W-1:0]      csr_base_id;

   id_table_scoreboard_type sb;
   int idle_pct;
   int sent;

   id_translation_table u_top (
      .clock, .reset, .start, .busy, .req_command, .req_key, .req_value,
      .rsp_valid, .rsp_result_id, .rsp_found, .rsp_status,
      .csr_valid, .csr_ready, .csr_base_id
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_response({rsp_result_id, rsp_found, rsp_status});
         if (start && !busy) sb.note_request(cmd_type'(req_command), req_key, req_value);
      end
   end

   // Drive one request and hold it until accepted, then idle at random
   task automatic send_request(cmd_type cmd, logic [ID_W-1:0] key, logic [ID_W-1:0] val);
      int gap;
      req_command = cmd;
      req_key = key;
      req_value = val;
      start = 1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      sent++;
      if ($urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 6);
         start = 0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Wait for all replies, then write the base id
   task automatic write_base(logic [BASE_W-1:0] b);
      start = 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_base_id = b;
      csr_valid = 1;
      do @(posedge clock); while (!csr_ready);
      sb.base = b;
      @(negedge clock);
      csr_valid = 0;
   endtask

   function automatic logic [ID_W-1:0] pick_key(logic [BASE_W-1:0] b);
      case ($urandom_range(9))
         0: return $urandom;
         1: begin
            case ($urandom_range(3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         2, 3, 4: return ID_W'(b) + ID_W'($urandom_range(1, 30));
         default: return ID_W'($urandom_range(1, 45));
      endcase
   endfunction

   function automatic logic [ID_W-1:0] pick_value();
      case ($urandom_range(7))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
         2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return ID_W'($urandom_range(1, 10));
      endcase
   endfunction

   // One random request, weighted toward table traffic that hits
   task automatic random_request();
      int              w;
      cmd_type         cmd;
      logic [ID_W-1:0] key;
      w = $urandom_range(99);
      if (w < 22) cmd = CMD_FWD;
      else if (w < 36) cmd = CMD_REV;
      else if (w < 62) cmd = CMD_UPD;
      else if (w < 72) cmd = CMD_ERASE;
      else if (w < 88) cmd = CMD_ALLOC;
      else if (w < 91) cmd = CMD_CLEAR;
      else if (w < 96) cmd = CMD_RSTAL;
      else cmd = CMD_NOP;
      key = pick_key(sb.base);
      // negated keys look up the magnitude
      if (cmd == CMD_FWD && $urandom_range(2) == 0) key = -key;
      send_request(cmd, key, pick_value());
   endtask

   initial begin
      int modes [3];
      logic [BASE_W-1:0] bases [4];
      modes = '{0, 81, 16};
      bases = '{23'h7F_FFFF, 23'd4194304, 23'd0, 23'd1000};
      sb = new();
      idle_pct = 0;
      sent = 0;
      reset = 1;
      start = 0;
      req_command = CMD_NOP;
      req_key = '0;
      req_value = '0;
      csr_valid = 0;
      csr_base_id = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: pass-through ids, sign handling, replace, allocator, erase, clear
      send_request(CMD_FWD, 32'h0, 32'h0);
      send_request(CMD_FWD, 32'hFFFF_FFFF, 32'h0);
      send_request(CMD_FWD, 32'd5, 32'h0);
      send_request(CMD_UPD, 32'd5, 32'd100);
      send_request(CMD_FWD, 32'd5, 32'h0);
      send_request(CMD_FWD, -32'sd5, 32'h0);
      send_request(CMD_UPD, 32'h8000_0000, 32'd7);
      send_request(CMD_FWD, 32'h8000_0000, 32'h0);
      send_request(CMD_UPD, 32'h7FFF_FFFF, 32'd7);
      send_request(CMD_REV, 32'h0, 32'd7);
      send_request(CMD_REV, 32'h0, 32'h0);
      send_request(CMD_REV, 32'h0, 32'hFFFF_FFFF);
      send_request(CMD_REV, 32'h0, 32'd99);
      send_request(CMD_UPD, 32'd5, 32'd7);
      send_request(CMD_REV, 32'h0, 32'd7);
      send_request(CMD_UPD, 32'd2, 32'h0);
      send_request(CMD_ALLOC, 32'h0, 32'h0);
      send_request(CMD_ALLOC, 32'h0, 32'h0);
      send_request(CMD_RSTAL, 32'h0, 32'h0);
      send_request(CMD_ALLOC, 32'h0, 32'h0);
      send_request(CMD_ERASE, 32'd5, 32'h0);
      send_request(CMD_ERASE, 32'd5, 32'h0);
      send_request(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_CLEAR, 32'h0, 32'h0);
      send_request(CMD_FWD, 32'd5, 32'h0);

      // Random phases over base ids and idle rates
      for (int p = 0; p < 12; p++) begin
         if (p % 3 == 0) write_base(bases[p / 3]);
         idle_pct = modes[p % 3];
         repeat (94) random_request();
      end

      start = 0;
      fork
         begin
            while (sb.pending.size() != 0) @(negedge clock);
         end
         begin
            repeat (200000) @(negedge clock);
            sb.errors++;
            $display("replies still pending after drain limit");
         end
      join_any
      disable fork;
      repeat (80) @(negedge clock);
      sb.errors += sb.pending.size();
      $display("sent %0d requests over 4 base ids, %0d replies, %0d lookup hits, %0d full",
               sent, sb.replies, sb.hits, sb.fulls);
      if (sb.errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("testbench: errors");
      end
      $finish;
   end

   // Guard against a hung block
   initial begin
      #200ms;
      $display("testbench: errors");
      $finish;
   end
endmodule

`default_nettype wire

// ===== filelist.f =====
src/itt_pkg.sv
src/itt_ram.sv
src/id_translation_table.sv
src/itt_checker.sv
dv/testbench.sv
